// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/smce_pkg.sv -----
package smce_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int IDX_W = $clog2(MAX_CLASSES);
    localparam int CNT_W = $clog2(MAX_CLASSES + 1);

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [23:0] LOSS_SAT  = 24'hFFFFFF;

    // 2^-(2^-(i+1)) in Q0.16
    function automatic logic [15:0] pow_entry(input logic [3:0] i);
        logic [15:0] r;
        begin
            case (i)
                4'd0:    r = 16'd46341;
                4'd1:    r = 16'd55109;
                4'd2:    r = 16'd60097;
                4'd3:    r = 16'd62757;
                4'd4:    r = 16'd64132;
                4'd5:    r = 16'd64830;
                4'd6:    r = 16'd65182;
                4'd7:    r = 16'd65359;
                4'd8:    r = 16'd65447;
                4'd9:    r = 16'd65492;
                4'd10:   r = 16'd65514;
                4'd11:   r = 16'd65525;
                4'd12:   r = 16'd65530;
                4'd13:   r = 16'd65533;
                default: r = 16'd65535;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- src/smce_mul.sv -----
// Shared 32x32 unsigned multiplier, registered product
module smce_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

// ----- src/smce_div.sv -----
// Restoring divider: quotient of a 48-bit dividend by a 37-bit divisor, one bit a cycle
module smce_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [47:0] dividend,
    input  logic [36:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);
    import smce_pkg::*;

    logic [37:0] rem_reg, rem_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [36:0] dsr_reg;
    logic [16:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next, done_reg, done_next;
    logic [38:0] trial;
    logic [37:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[36:0], dvd_reg[47]};
        trial     = {1'b0, shifted} - {2'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next = '0;
            dvd_next = dividend;
            q_next   = '0;
            cnt_next = 6'd48;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[46:0], 1'b0};
            if (!trial[38])
            begin
                rem_next = trial[37:0];
                q_next   = {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        dsr_reg <= go ? divisor : dsr_reg;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ----- src/softmax_argmax_crossentropy.sv -----
// Softmax head. Logits load at one per cycle (busy stays low) until the
// row_end transfer. Then busy rises while a sequencer runs one shared
// 32x32 multiplier: the exponential of each class (one multiply per set
// fraction bit), then the log of the sum. A second pass, first for the
// argmax class and then for every class in order, recomputes the
// exponential and divides it in a bit-serial divider; each class of the
// ordered sweep then strobes its result out. The last result strobes in
// the cycle where busy falls.
// Results cannot be stalled: each is valid for exactly one cycle on done.
`include "assert_macros.svh"
module softmax_argmax_crossentropy (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  logit,
    input  logic [5:0]          label,
    input  logic                row_end,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output logic                done,
    output logic [5:0]          class_index,
    output logic [16:0]         probability,
    output logic signed [17:0]  gradient,
    output logic [5:0]          best_index,
    output logic [16:0]         best_confidence,
    output logic [23:0]         row_loss,
    output logic [31:0]         loss_total,
    output logic                final_res
);
    import smce_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_XM    = 4'd2;
    localparam logic [3:0] S_XW    = 4'd3;
    localparam logic [3:0] S_EM    = 4'd4;
    localparam logic [3:0] S_EW    = 4'd5;
    localparam logic [3:0] S_LM    = 4'd6;
    localparam logic [3:0] S_LW    = 4'd7;
    localparam logic [3:0] S_LN    = 4'd8;
    localparam logic [3:0] S_LNW   = 4'd9;
    localparam logic [3:0] S_PRD   = 4'd10;
    localparam logic [3:0] S_PXM   = 4'd11;
    localparam logic [3:0] S_PXW   = 4'd12;
    localparam logic [3:0] S_PEM   = 4'd13;
    localparam logic [3:0] S_PEW   = 4'd14;
    localparam logic [3:0] S_DIV   = 4'd15;

    logic [15:0] store [MAX_CLASSES];
    logic signed [15:0] rd_reg;

    logic [3:0]  st_reg, st_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic signed [15:0] max_reg, max_next;
    logic [31:0] acc_reg, acc_next;
    logic        train_reg;
    logic [5:0]  label_reg, label_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic        found_reg, found_next;
    logic [4:0]  bit_reg, bit_next;
    logic [15:0] frac_reg, frac_next;
    logic [8:0]  n_reg, n_next;
    logic [31:0] e_reg, e_next;
    logic [36:0] sum_reg, sum_next;
    logic [15:0] xlab_reg, xlab_next;
    logic [31:0] m_reg, m_next;
    logic [21:0] l_reg, l_next;
    logic [23:0] loss_reg, loss_next;
    logic [31:0] ma, mb;
    logic [63:0] mp;
    logic        go;
    logic [47:0] dvd;
    logic        dv_done;
    logic [16:0] q;
    logic        phase_reg, phase_next;
    logic [16:0] bconf_reg, bconf_next;
    logic        done_reg;
    logic [5:0]  ci_reg;
    logic [16:0] p_reg;
    logic [17:0] g_reg;
    logic [5:0]  bi_reg;
    logic [16:0] bc_reg;
    logic [23:0] rl_reg;
    logic [31:0] lt_reg;
    logic        fr_reg;
    logic        emit;
    logic [15:0] xval;
    logic [5:0]  k_sum;
    logic [36:0] sh_sum;
    logic [24:0] rl_wide;
    logic [32:0] acc_sum;
    logic        acc_go;
    // high while the pass for the argmax probability runs
    logic        bc_pend_reg;

    smce_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
    smce_div u_div (.clk(clk), .rst_n(rst_n), .go(go), .dividend(dvd),
                    .divisor(sum_reg), .done(dv_done), .quotient(q));

    assign busy = (st_reg != S_LOAD);
    assign xval = 16'(max_reg - rd_reg);
    assign dvd  = {e_reg, 16'd0} + {12'd0, sum_reg[36:1]};

    always_ff @(posedge clk)
    begin
        if (start && !busy && fill_reg != CNT_W'(MAX_CLASSES))
            store[fill_reg[IDX_W-1:0]] <= logit;
        rd_reg <= store[idx_next];
    end

    // integer part of log2(sum/2^30)
    always_comb
    begin
        k_sum = '0;
        for (int i = 31; i <= 36; i++)
            if (sum_reg[i])
                k_sum = 6'(i - 30);
        sh_sum = sum_reg >> k_sum;
    end

    always_comb
    begin
        st_next    = st_reg;
        fill_next  = fill_reg;
        max_next   = max_reg;
        acc_next   = acc_reg;
        label_next = label_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        found_next = found_reg;
        bit_next   = bit_reg;
        frac_next  = frac_reg;
        n_next     = n_reg;
        e_next     = e_reg;
        sum_next   = sum_reg;
        xlab_next  = xlab_reg;
        m_next     = m_reg;
        l_next     = l_reg;
        loss_next  = loss_reg;
        phase_next = phase_reg;
        bconf_next = bconf_reg;
        ma = '0;
        mb = '0;
        go = 1'b0;
        emit = 1'b0;
        rl_wide = '0;
        acc_sum = '0;
        acc_go = 1'b0;
        case (st_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    if (fill_reg != CNT_W'(MAX_CLASSES))
                    begin
                        fill_next = fill_reg + 1'b1;
                        if (logit > max_reg)
                            max_next = logit;
                    end
                    if (row_end)
                    begin
                        label_next = label;
                        idx_next   = '0;
                        sum_next   = '0;
                        found_next = 1'b0;
                        best_next  = '0;
                        loss_next  = '0;
                        st_next    = S_RD;
                    end
                end
            end
            S_RD: st_next = S_XM;
            S_XM:
            begin
                ma = {16'd0, xval};
                mb = {15'd0, LOG2E_Q16};
                if (!found_reg && rd_reg == max_reg)
                begin
                    found_next = 1'b1;
                    best_next  = idx_reg;
                end
                if (idx_reg == label_reg)
                    xlab_next = xval;
                st_next = S_XW;
            end
            S_XW:
            begin
                n_next    = mp[32:24];
                frac_next = mp[23:8];
                e_next    = 32'h4000_0000;
                bit_next  = '0;
                st_next   = S_EM;
            end
            S_EM:
            begin
                if (bit_reg == 5'd16)
                begin
                    e_next = (n_reg >= 9'd31) ? 32'd0 : (e_reg >> n_reg[4:0]);
                    st_next = S_EW;
                end
                else if (frac_reg[15])
                begin
                    ma = e_reg;
                    mb = {16'd0, pow_entry(bit_reg[3:0])};
                    st_next = S_EW;
                end
                else
                begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    bit_next  = bit_reg + 5'd1;
                end
            end
            S_EW:
            begin
                if (bit_reg == 5'd16)
                begin
                    if (phase_reg)
                    begin
                        go = 1'b1;
                        st_next = S_DIV;
                    end
                    else
                    begin
                        sum_next = sum_reg + 37'(e_reg);
                        if ({1'b0, idx_reg} + 1'b1 == fill_reg)
                        begin
                            st_next = S_LM;
                            bit_next = 5'd16;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            st_next  = S_RD;
                        end
                    end
                end
                else
                begin
                    e_next    = mp[47:16];
                    frac_next = {frac_reg[14:0], 1'b0};
                    bit_next  = bit_reg + 5'd1;
                    st_next   = S_EM;
                end
            end
            S_LM:
            begin
                // first visit: set up log from the finished sum
                if (bit_reg == 5'd16)
                begin
                    m_next   = sh_sum[31:0];
                    l_next   = {k_sum, 16'd0};
                    bit_next = 5'd15;
                end
                else
                begin
                    ma = m_reg;
                    mb = m_reg;
                    st_next = S_LW;
                end
            end
            S_LW:
            begin
                if (mp[61])
                begin
                    m_next = {1'b0, mp[61:31]};
                    l_next = l_reg | (22'd1 << bit_reg[3:0]);
                end
                else
                    m_next = mp[61:30];
                if (bit_reg == 5'd0)
                    st_next = S_LN;
                else
                begin
                    bit_next = bit_reg - 5'd1;
                    st_next  = S_LM;
                end
            end
            S_LN:
            begin
                ma = {10'd0, l_reg};
                mb = {16'd0, LN2_Q16};
                st_next = S_LNW;
            end
            S_LNW:
            begin
                if (train_reg && {1'b0, label_reg} < 7'(fill_reg))
                begin
                    rl_wide = 25'({xlab_reg, 8'd0}) + 25'((mp + 64'd32768) >> 16);
                    loss_next = rl_wide[24] ? LOSS_SAT : rl_wide[23:0];
                    acc_sum = {1'b0, acc_reg} + 33'(loss_next);
                    acc_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                end
                phase_next = 1'b1;
                idx_next = best_reg;
                st_next = S_PRD;
                acc_go = 1'b1;
            end
            S_PRD: st_next = S_PXM;
            S_PXM:
            begin
                ma = {16'd0, xval};
                mb = {15'd0, LOG2E_Q16};
                st_next = S_PXW;
            end
            S_PXW:
            begin
                n_next    = mp[32:24];
                frac_next = mp[23:8];
                e_next    = 32'h4000_0000;
                bit_next  = '0;
                st_next   = S_EM;
            end
            S_DIV:
            begin
                if (dv_done)
                begin
                    if (bc_pend_reg)
                    begin
                        bconf_next = q;
                        idx_next = '0;
                        st_next = S_PRD;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if ({1'b0, idx_reg} + 1'b1 == fill_reg)
                        begin
                            fill_next  = '0;
                            max_next   = 16'sh8000;
                            phase_next = 1'b0;
                            st_next    = S_LOAD;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            st_next  = S_PRD;
                        end
                    end
                end
            end
            default: st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_LOAD;
            fill_reg    <= '0;
            max_reg     <= 16'sh8000;
            acc_reg     <= '0;
            train_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            done_reg    <= 1'b0;
            bc_pend_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            fill_reg  <= fill_next;
            max_reg   <= max_next;
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            done_reg  <= emit;
            if (cfg_we)
                train_reg <= cfg_wdata;
            if (acc_go)
                bc_pend_reg <= 1'b1;
            else if (st_reg == S_DIV && dv_done)
                bc_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        bit_reg   <= bit_next;
        frac_reg  <= frac_next;
        n_reg     <= n_next;
        e_reg     <= e_next;
        sum_reg   <= sum_next;
        xlab_reg  <= xlab_next;
        m_reg     <= m_next;
        l_reg     <= l_next;
        loss_reg  <= loss_next;
        bconf_reg <= bconf_next;
        if (emit)
        begin
            ci_reg <= 6'(idx_reg);
            p_reg  <= q;
            if (!train_reg)
                g_reg <= '0;
            else if (6'(idx_reg) == label_reg)
                g_reg <= {1'b0, q} - 18'd65536;
            else
                g_reg <= {1'b0, q};
            fr_reg <= ({1'b0, idx_reg} + 1'b1 == fill_reg);
            bi_reg <= ({1'b0, idx_reg} + 1'b1 == fill_reg) ? 6'(best_reg) : 6'd0;
            bc_reg <= ({1'b0, idx_reg} + 1'b1 == fill_reg) ? bconf_reg : 17'd0;
            rl_reg <= train_reg ? loss_reg : 24'd0;
            lt_reg <= acc_reg;
        end
    end

    assign done            = done_reg;
    assign class_index     = ci_reg;
    assign probability     = p_reg;
    assign gradient        = g_reg;
    assign best_index      = bi_reg;
    assign best_confidence = bc_reg;
    assign row_loss        = rl_reg;
    assign loss_total      = lt_reg;
    assign final_res       = fr_reg;

    `ASSERT_IMPL(a_busy_mid_row, clk, rst_n, done && !final_res, busy)
    `ASSERT_IMPL(a_final_returns, clk, rst_n, done && final_res, !busy)
    `ASSERT_NEXT(a_row_end_busy, clk, rst_n, start && !busy && row_end, busy)
    `ASSERT_IMPL(a_prob_range, clk, rst_n, done, probability <= 17'd65536)
endmodule

// ----- tb/sv/softmax_argmax_crossentropy_tb.sv -----
module softmax_argmax_crossentropy_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smce_pkg::*;

    typedef struct packed {
        logic [5:0]  class_index;
        logic [16:0] probability;
        logic [17:0] gradient;
        logic [5:0]  best_index;
        logic [16:0] best_confidence;
        logic [23:0] row_loss;
        logic [31:0] loss_total;
        logic        final_res;
    } softmax_result_t;

    class softmax_scoreboard;
        softmax_result_t pending_results[$];
        logic signed [15:0] stored_logit[MAX_CLASSES];
        int unsigned   stored_count;
        logic signed [15:0] peak_logit;
        logic [31:0]   running_loss;
        bit            train_on;
        int            mismatch_count;

        function new();
            stored_count = 0;
            peak_logit = -16'sd32768;
            running_loss = 0;
            train_on = 0;
            mismatch_count = 0;
        endfunction

        function logic [63:0] exp_of_gap(logic [31:0] gap);
            logic [63:0] scaled;
            logic [63:0] acc;
            logic [63:0] whole;
            logic [15:0] frac;
            scaled = gap * 64'd94548;
            whole = scaled >> 24;
            frac = scaled[23:8];
            acc = 64'd1 << 30;
            for (int k = 0; k < 16; k++)
                if (frac[15 - k])
                    acc = (acc * pow_entry(k[3:0])) >> 16;
            if (whole >= 31)
                return 64'd0;
            return acc >> whole;
        endfunction

        function logic [63:0] ln_of_sum(logic [63:0] s);
            int unsigned sh;
            logic [63:0] m;
            logic [63:0] l;
            sh = 0;
            while (sh < 40 && (s >> sh) >= (64'd1 << 31))
                sh++;
            m = s >> sh;
            l = 64'(sh) << 16;
            for (int b = 15; b >= 0; b--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    l[b] = 1'b1;
                    m = m >> 1;
                end
            end
            return (l * 64'd45426 + 64'd32768) >> 16;
        endfunction

        function void note_logit(logic signed [15:0] v, logic [5:0] lbl, logic last);
            logic [63:0] e[MAX_CLASSES];
            logic [63:0] total;
            logic [63:0] loss;
            logic [63:0] p;
            logic [63:0] t;
            int unsigned best;
            bit found;
            softmax_result_t r;
            if (stored_count < MAX_CLASSES)
            begin
                stored_logit[stored_count] = v;
                stored_count++;
                if (v > peak_logit)
                    peak_logit = v;
            end
            if (!last)
                return;
            total = 0;
            best = 0;
            found = 0;
            loss = 0;
            for (int i = 0; i < stored_count; i++)
            begin
                e[i] = exp_of_gap(32'(int'(peak_logit) - int'(stored_logit[i])));
                total += e[i];
                if (!found && stored_logit[i] == peak_logit)
                begin
                    best = i;
                    found = 1;
                end
            end
            if (total == 0)
                total = 1;
            if (train_on && lbl < stored_count)
            begin
                loss = (64'(32'(int'(peak_logit) - int'(stored_logit[lbl]))) << 8)
                       + ln_of_sum(total);
                if (loss > 64'hFFFFFF)
                    loss = 64'hFFFFFF;
                t = 64'(running_loss) + loss;
                running_loss = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
            end
            for (int i = 0; i < stored_count; i++)
            begin
                p = ((e[i] << 16) + total / 2) / total;
                r.class_index = i[5:0];
                r.probability = p[16:0];
                r.gradient = !train_on ? 18'd0 :
                             (i == lbl) ? 18'(p - 64'd65536) : p[17:0];
                r.final_res = (i + 1 == stored_count);
                r.best_index = r.final_res ? best[5:0] : 6'd0;
                t = ((e[best] << 16) + total / 2) / total;
                r.best_confidence = r.final_res ? t[16:0] : 17'd0;
                r.row_loss = loss[23:0];
                r.loss_total = running_loss;
                pending_results.push_back(r);
            end
            stored_count = 0;
            peak_logit = -16'sd32768;
        endfunction

        function void check_result(softmax_result_t got);
            softmax_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result class %0d", got.class_index);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch exp cls=%0d p=%0d g=%0d bi=%0d bc=%0d rl=%0d lt=%0d f=%0d | got cls=%0d p=%0d g=%0d bi=%0d bc=%0d rl=%0d lt=%0d f=%0d",
                        want.class_index, want.probability, want.gradient,
                        want.best_index, want.best_confidence, want.row_loss,
                        want.loss_total, want.final_res,
                        got.class_index, got.probability, got.gradient,
                        got.best_index, got.best_confidence, got.row_loss,
                        got.loss_total, got.final_res);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] logit = 0;
    logic [5:0] label = 0;
    logic row_end = 0;
    logic cfg_we = 0;
    logic cfg_wdata = 0;
    logic done;
    logic [5:0] class_index;
    logic [16:0] probability;
    logic signed [17:0] gradient;
    logic [5:0] best_index;
    logic [16:0] best_confidence;
    logic [23:0] row_loss;
    logic [31:0] loss_total;
    logic final_res;

    softmax_argmax_crossentropy dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .logit(logit), .label(label), .row_end(row_end),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .class_index(class_index), .probability(probability),
        .gradient(gradient), .best_index(best_index),
        .best_confidence(best_confidence), .row_loss(row_loss),
        .loss_total(loss_total), .final_res(final_res)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    softmax_scoreboard sb = new();
    int idle_pct = 0;
    int quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 40000;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            softmax_result_t r;
            r.class_index = class_index;
            r.probability = probability;
            r.gradient = gradient;
            r.best_index = best_index;
            r.best_confidence = best_confidence;
            r.row_loss = row_loss;
            r.loss_total = loss_total;
            r.final_res = final_res;
            sb.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one logit and hold it until the transfer
    task automatic send_logit(logic signed [15:0] v, logic [5:0] lbl, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        logit <= v;
        label <= lbl;
        row_end <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_logit(v, lbl, last);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_train(logic m);
        drain();
        cfg_we <= 1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 0;
        sb.train_on = m;
    endtask

    task automatic send_row(int n, logic [5:0] lbl, int spread);
        logic signed [15:0] v;
        for (int i = 0; i < n; i++)
        begin
            case (spread)
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(2047) - 1024);
                default: v = 16'($urandom_range(3));
            endcase
            send_logit(v, lbl, i == n - 1);
        end
    endtask

    int sent;
    int n;

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: extremes, ties, single class, label outside the row
        send_logit(16'sh7FFF, 6'd0, 1'b0);
        send_logit(-16'sh8000, 6'd0, 1'b1);
        set_train(1'b1);
        send_logit(-16'sh8000, 6'd1, 1'b0);
        send_logit(16'sh7FFF, 6'd1, 1'b1);
        send_logit(16'sh0100, 6'd0, 1'b0);
        send_logit(16'sh0100, 6'd0, 1'b0);
        send_logit(16'sh0000, 6'd2, 1'b1);
        send_logit(16'sh1234, 6'd5, 1'b1);
        send_logit(-16'sh8000, 6'd0, 1'b0);
        send_logit(16'sh7FFF, 6'd0, 1'b1);
        send_row(3, 6'd63, 1);
        set_train(1'b0);
        send_row(4, 6'd1, 2);
        set_train(1'b1);
        // overfull row: logits past the store capacity are dropped
        send_row(66, 6'd63, 1);
        drain();
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 11 : (ph == 1) ? 76 : 0;
            set_train(1'($urandom_range(1)));
            while (sent < (ph + 1) * 95)
            begin
                n = int'(($urandom_range(9) == 0) ? $urandom_range(64, 30)
                                                  : $urandom_range(8, 1));
                send_row(n, 6'(($urandom_range(3) == 0) ? $urandom : $urandom_range(n - 1)),
                         int'($urandom_range(2)));
                sent += n;
            end
            if (ph == 1)
                drain();
        end
        drain();
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
